// ===== rtl/core/pnca_pkg.sv =====
// Package for the periodic nearest-centre assignment block.
// Holds the beat types, command and status structs, constants and state codes.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package pnca_pkg;

  localparam int MAX_CENTERS = 1024;
  localparam int CIDX_W      = 10;
  localparam int CNT_W       = 11;
  localparam int COORD_BITS  = 32;
  localparam int COORD_W     = 32;
  localparam int ID_W        = 32;
  localparam int CQ_DEPTH    = 2;
  localparam int CQ_PTR_W    = $clog2(CQ_DEPTH);
  localparam int CQ_CNT_W    = $clog2(CQ_DEPTH + 1);
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_W       = 32;

  localparam logic [COORD_W-1:0] COORD_MASK = COORD_W'((64'd1 << COORD_BITS) - 64'd1);

  localparam logic [CFG_IDX_W-1:0] REG_CENTER_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_SIZE     = 1'b1;

  localparam logic [3:0] MS_DX    = 4'd0;
  localparam logic [3:0] MS_DY    = 4'd1;
  localparam logic [3:0] MS_DZ    = 4'd2;
  localparam logic [3:0] MS_RSQ   = 4'd3;
  localparam logic [3:0] MS_L00   = 4'd4;
  localparam logic [3:0] MS_L01   = 4'd5;
  localparam logic [3:0] MS_L10   = 4'd6;
  localparam logic [3:0] MS_L11   = 4'd7;
  localparam logic [3:0] MS_R00   = 4'd8;
  localparam logic [3:0] MS_R01   = 4'd9;
  localparam logic [3:0] MS_R10   = 4'd10;
  localparam logic [3:0] MS_R11   = 4'd11;
  localparam logic [3:0] MS_LAST  = 4'd12;

  typedef enum logic {
    CMD_LOAD,
    CMD_CLASSIFY
  } cmd_kind_t;

  typedef struct packed {
    logic              mode;
    logic [CIDX_W-1:0] center_index;
    logic [31:0]       pos_x;
    logic [31:0]       pos_y;
    logic [31:0]       pos_z;
    logic [31:0]       radius;
    logic [ID_W-1:0]   orig_id;
    logic [ID_W-1:0]   local_index;
  } in_item_t;

  typedef struct packed {
    logic              found;
    logic [CIDX_W-1:0] assigned_center;
    logic [ID_W-1:0]   out_orig_id;
    logic [ID_W-1:0]   out_local_index;
    logic [31:0]       member_slot;
  } out_item_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [CIDX_W-1:0]  idx;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
    logic [31:0]        r;
    logic [ID_W-1:0]    orig_id;
    logic [ID_W-1:0]    local_index;
  } cmd_t;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
    logic [31:0]        r;
  } entry_t;

  typedef struct packed {
    logic [CNT_W-1:0] center_count;
    logic [31:0]      box_size;
  } cfg_t;

  typedef struct packed {
    logic clearing;
  } back_stat_t;

  typedef enum logic [3:0] {
    B_CLEAR,
    B_IDLE,
    B_FETCH,
    B_DIFF,
    B_MOD,
    B_IMAGE,
    B_MUL,
    B_CMP,
    B_CNT_RD,
    B_CNT_WR,
    B_EMIT
  } back_state_t;

endpackage
`default_nettype wire

// ===== rtl/core/pnca_front.sv =====
// Front end: takes input beats, masks coordinates and sorts them into commands.
// Depends on pnca_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pnca_front
  import pnca_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  output logic          full,
  input  wire in_item_t in_data,
  input  wire logic     clearing,
  input  wire logic     q_full,
  output logic          q_push,
  output cmd_t          q_cmd
);

  logic hold_v_r;
  cmd_t hold_r;
  cmd_t cmd_nxt;
  logic accept;
  logic keep;

  assign full   = clearing || (hold_v_r && q_full);
  assign accept = push && !full;
  assign q_push = hold_v_r;
  assign q_cmd  = hold_r;

  always_comb begin
    cmd_nxt.kind        = in_data.mode ? CMD_CLASSIFY : CMD_LOAD;
    cmd_nxt.idx         = in_data.center_index;
    cmd_nxt.x           = in_data.pos_x & COORD_MASK;
    cmd_nxt.y           = in_data.pos_y & COORD_MASK;
    cmd_nxt.z           = in_data.pos_z & COORD_MASK;
    cmd_nxt.r           = in_data.radius;
    cmd_nxt.orig_id     = in_data.orig_id;
    cmd_nxt.local_index = in_data.local_index;
    keep = in_data.mode || ({1'b0, in_data.center_index} < CNT_W'(MAX_CENTERS));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
    end else if (accept) begin
      hold_v_r <= keep;
    end else if (hold_v_r && !q_full) begin
      hold_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_r <= cmd_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/pnca_cmd_queue.sv =====
// Short command queue between the front end and the back end.
// Depends on pnca_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pnca_cmd_queue
  import pnca_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire cmd_t cmd_in,
  output logic      full,
  input  wire logic pop,
  output cmd_t      cmd_out,
  output logic      empty
);

  cmd_t                slot_r [CQ_DEPTH];
  logic [CQ_PTR_W-1:0] wr_ptr_r;
  logic [CQ_PTR_W-1:0] rd_ptr_r;
  logic [CQ_CNT_W-1:0] count_r;
  logic                do_push;
  logic                do_pop;

  assign full    = (count_r == CQ_CNT_W'(CQ_DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign cmd_out = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == CQ_PTR_W'(CQ_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == CQ_PTR_W'(CQ_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= cmd_in;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/pnca_back.sv =====
// Back end: centre table, member counters, scan sequencer with a shared multiplier.
// Depends on pnca_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pnca_back
  import pnca_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire cfg_t  cfg,
  input  wire logic  q_empty,
  input  wire cmd_t  q_cmd,
  output logic       q_pop,
  output back_stat_t status,
  output logic       empty,
  input  wire logic  pop,
  output out_item_t  out_data
);

  entry_t      tbl_mem [MAX_CENTERS];
  logic [31:0] cnt_mem [MAX_CENTERS];

  back_state_t state_r, state_nxt;
  cmd_t             part_r;
  logic [CNT_W-1:0] n_r;
  logic [CIDX_W-1:0] i_r;
  logic [CIDX_W-1:0] clr_addr_r;
  entry_t           ent_r;
  logic [31:0]      d_r   [3];
  logic [32:0]      rem_r [3];
  logic [4:0]       bit_r;
  logic [31:0]      r_r;
  logic [3:0]       mstep_r;
  logic [63:0]      p_r;
  logic [63:0]      dsum_r;
  logic [63:0]      rsq_r;
  logic [127:0]     lhs_r;
  logic [127:0]     rhs_r;
  logic             have_r;
  logic [CIDX_W-1:0] best_r;
  logic [63:0]      best_d_r;
  logic [63:0]      best_rsq_r;
  logic [31:0]      cnt_rd_r;
  logic [31:0]      slot_r;
  logic             out_v_r;
  out_item_t        out_r;

  logic [32:0]      box_eff;
  logic [CNT_W-1:0] n_sat;
  logic             last;
  logic [31:0]      diff [3];
  logic             any_big;
  logic [31:0]      a_op;
  logic [31:0]      b_op;
  logic [31:0]      cnt_inc;
  logic             tbl_we;
  logic             emit_go;

  function automatic logic [31:0] abs_diff(input logic [31:0] a, input logic [31:0] b);
    abs_diff = (a > b) ? a - b : b - a;
  endfunction

  assign box_eff = (cfg.box_size == '0) ? {1'b1, 32'd0} : {1'b0, cfg.box_size};
  assign n_sat   = (cfg.center_count > CNT_W'(MAX_CENTERS)) ? CNT_W'(MAX_CENTERS)
                                                          : cfg.center_count;
  assign last    = (({1'b0, i_r} + 1'b1) == n_r);
  assign diff[0] = abs_diff(part_r.x, ent_r.x);
  assign diff[1] = abs_diff(part_r.y, ent_r.y);
  assign diff[2] = abs_diff(part_r.z, ent_r.z);
  assign any_big = ({1'b0, diff[0]} >= box_eff) || ({1'b0, diff[1]} >= box_eff) ||
                   ({1'b0, diff[2]} >= box_eff);
  assign cnt_inc = (cnt_rd_r == 32'hFFFF_FFFF) ? cnt_rd_r : cnt_rd_r + 32'd1;
  assign q_pop   = (state_r == B_IDLE) && !q_empty;
  assign tbl_we  = q_pop && (q_cmd.kind == CMD_LOAD);
  assign emit_go = (state_r == B_EMIT) && (!out_v_r || pop);
  assign status.clearing = (state_r == B_CLEAR);
  assign empty    = !out_v_r;
  assign out_data = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_CLEAR: begin
        if (clr_addr_r == CIDX_W'(MAX_CENTERS - 1)) begin
          state_nxt = B_IDLE;
        end
      end
      B_IDLE: begin
        if (!q_empty && q_cmd.kind == CMD_CLASSIFY) begin
          state_nxt = (n_sat == '0) ? B_CNT_RD : B_FETCH;
        end
      end
      B_FETCH: state_nxt = B_DIFF;
      B_DIFF: begin
        if (ent_r.r == '0) begin
          state_nxt = last ? B_CNT_RD : B_FETCH;
        end else begin
          state_nxt = any_big ? B_MOD : B_IMAGE;
        end
      end
      B_MOD: begin
        if (bit_r == 5'd31) begin
          state_nxt = B_IMAGE;
        end
      end
      B_IMAGE: state_nxt = B_MUL;
      B_MUL: begin
        if (mstep_r == MS_LAST) begin
          state_nxt = B_CMP;
        end
      end
      B_CMP:    state_nxt = last ? B_CNT_RD : B_FETCH;
      B_CNT_RD: state_nxt = have_r ? B_CNT_WR : B_EMIT;
      B_CNT_WR: state_nxt = B_EMIT;
      B_EMIT: begin
        if (emit_go) begin
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_comb begin
    a_op = '0;
    b_op = '0;
    case (mstep_r) inside
      MS_DX:  begin a_op = d_r[0];             b_op = d_r[0];              end
      MS_DY:  begin a_op = d_r[1];             b_op = d_r[1];              end
      MS_DZ:  begin a_op = d_r[2];             b_op = d_r[2];              end
      MS_RSQ: begin a_op = r_r;                b_op = r_r;                 end
      MS_L00: begin a_op = dsum_r[31:0];       b_op = best_rsq_r[31:0];    end
      MS_L01: begin a_op = dsum_r[31:0];       b_op = best_rsq_r[63:32];   end
      MS_L10: begin a_op = dsum_r[63:32];      b_op = best_rsq_r[31:0];    end
      MS_L11: begin a_op = dsum_r[63:32];      b_op = best_rsq_r[63:32];   end
      MS_R00: begin a_op = best_d_r[31:0];     b_op = rsq_r[31:0];         end
      MS_R01: begin a_op = best_d_r[31:0];     b_op = rsq_r[63:32];        end
      MS_R10: begin a_op = best_d_r[63:32];    b_op = rsq_r[31:0];         end
      MS_R11: begin a_op = best_d_r[63:32];    b_op = rsq_r[63:32];        end
      default: begin a_op = '0;                b_op = '0;                  end
    endcase
  end

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tbl_mem[q_cmd.idx] <= '{x: q_cmd.x, y: q_cmd.y, z: q_cmd.z, r: q_cmd.r};
    end
    ent_r <= tbl_mem[i_r];
  end

  always_ff @(posedge clk) begin
    if (state_r == B_CLEAR) begin
      cnt_mem[clr_addr_r] <= '0;
    end else if (state_r == B_CNT_WR) begin
      cnt_mem[best_r] <= cnt_inc;
    end
    cnt_rd_r <= cnt_mem[best_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
      have_r     <= 1'b0;
      out_v_r    <= 1'b0;
      i_r        <= '0;
      mstep_r    <= '0;
      bit_r      <= '0;
    end else begin
      if (state_r == B_CLEAR) begin
        clr_addr_r <= clr_addr_r + 1'b1;
      end
      if (q_pop && q_cmd.kind == CMD_CLASSIFY) begin
        have_r <= 1'b0;
        i_r    <= '0;
      end
      if ((state_r == B_DIFF && ent_r.r == '0) || state_r == B_CMP) begin
        i_r <= i_r + 1'b1;
      end
      if (state_r == B_CMP && (!have_r || lhs_r < rhs_r)) begin
        have_r <= 1'b1;
      end
      if (state_r == B_DIFF) begin
        bit_r <= '0;
      end else if (state_r == B_MOD) begin
        bit_r <= bit_r + 1'b1;
      end
      if (state_r == B_IMAGE) begin
        mstep_r <= '0;
      end else if (state_r == B_MUL) begin
        mstep_r <= mstep_r + 1'b1;
      end
      if (emit_go) begin
        out_v_r <= 1'b1;
      end else if (pop && out_v_r) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_cmd.kind == CMD_CLASSIFY) begin
      part_r <= q_cmd;
      n_r    <= n_sat;
    end
    if (state_r == B_DIFF) begin
      r_r <= ent_r.r;
      for (int a = 0; a < 3; a++) begin
        d_r[a]   <= diff[a];
        rem_r[a] <= any_big ? 33'd0 : {1'b0, diff[a]};
      end
    end
    if (state_r == B_MOD) begin
      for (int a = 0; a < 3; a++) begin
        logic [32:0] sh;
        sh = {rem_r[a][31:0], d_r[a][31]};
        rem_r[a] <= (sh >= box_eff) ? sh - box_eff : sh;
        d_r[a]   <= {d_r[a][30:0], 1'b0};
      end
    end
    if (state_r == B_IMAGE) begin
      for (int a = 0; a < 3; a++) begin
        logic [32:0] alt;
        alt = box_eff - {1'b0, rem_r[a][31:0]};
        d_r[a] <= (alt < {1'b0, rem_r[a][31:0]}) ? alt[31:0] : rem_r[a][31:0];
      end
      dsum_r <= '0;
      lhs_r  <= '0;
      rhs_r  <= '0;
    end
    if (state_r == B_MUL) begin
      p_r <= 64'(a_op) * 64'(b_op);
      case (mstep_r - 4'd1) inside
        MS_DX, MS_DY, MS_DZ: dsum_r <= dsum_r + p_r;
        MS_RSQ:              rsq_r  <= p_r;
        MS_L00:              lhs_r  <= lhs_r + {64'd0, p_r};
        MS_L01, MS_L10:      lhs_r  <= lhs_r + {32'd0, p_r, 32'd0};
        MS_L11:              lhs_r  <= lhs_r + {p_r, 64'd0};
        MS_R00:              rhs_r  <= rhs_r + {64'd0, p_r};
        MS_R01, MS_R10:      rhs_r  <= rhs_r + {32'd0, p_r, 32'd0};
        MS_R11:              rhs_r  <= rhs_r + {p_r, 64'd0};
        default: ;
      endcase
    end
    if (state_r == B_CMP && (!have_r || lhs_r < rhs_r)) begin
      best_r     <= i_r;
      best_d_r   <= dsum_r;
      best_rsq_r <= rsq_r;
    end
    if (state_r == B_CNT_RD) begin
      slot_r <= '0;
    end else if (state_r == B_CNT_WR) begin
      slot_r <= cnt_inc;
    end
    if (emit_go) begin
      out_r.found           <= have_r;
      out_r.assigned_center <= have_r ? best_r : '0;
      out_r.out_orig_id     <= part_r.orig_id;
      out_r.out_local_index <= part_r.local_index;
      out_r.member_slot     <= slot_r;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/periodic_nearest_center_assign.sv =====
// Top level of the periodic nearest-centre assignment block.
// Depends on pnca_pkg, pnca_front, pnca_cmd_queue and pnca_back.
//
// Load beats (mode 0) write one centre entry; a particle beat (mode 1) yields one
// result beat. For each searched centre the back end fetches the entry and forms
// the axis differences; a centre whose radius is zero is skipped there. Otherwise
// it reduces the differences modulo the box edge bit by bit when one of them is
// not below the box edge, takes the minimum image and then runs the single 32 by
// 32 multiplier, which forms twelve partial products for the squared distance, the
// squared radius and the exact cross-multiplied comparison. After reset the member
// counters are cleared, one per cycle, and full is high while they are cleared.
// The user must see that configuration is written only while the block is idle; the block does not enforce it.
`timescale 1ns / 1ps
`default_nettype none
module periodic_nearest_center_assign
  import pnca_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  output logic                      full,
  input  wire in_item_t             in_data,
  output logic                      empty,
  input  wire logic                 pop,
  output out_item_t                 out_data,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data
);

  cfg_t       cfg_r;
  back_stat_t status;
  logic       q_full;
  logic       q_push;
  cmd_t       q_in;
  logic       q_empty;
  logic       q_pop;
  cmd_t       q_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.center_count <= '0;
      cfg_r.box_size     <= 32'hFFFF_FFFF;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CENTER_COUNT: cfg_r.center_count <= cfg_data[CNT_W-1:0];
        REG_BOX_SIZE:     cfg_r.box_size     <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  pnca_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_data  (in_data),
    .clearing (status.clearing),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (q_in)
  );

  pnca_cmd_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .cmd_in  (q_in),
    .full    (q_full),
    .pop     (q_pop),
    .cmd_out (q_out),
    .empty   (q_empty)
  );

  pnca_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .q_empty  (q_empty),
    .q_cmd    (q_out),
    .q_pop    (q_pop),
    .status   (status),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

endmodule
`default_nettype wire

// ===== rtl/core/pnca_checker.sv =====
// Port-level checks for the periodic nearest-centre assignment block, and its bind.
// Depends on pnca_pkg and the top level's ports.
`timescale 1ns / 1ps
`default_nettype none
module pnca_checker
  import pnca_pkg::*;
(
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 push,
  input wire logic                 full,
  input wire in_item_t             in_data,
  input wire logic                 empty,
  input wire logic                 pop,
  input wire out_item_t            out_data,
  input wire logic                 cfg_we,
  input wire logic [CFG_IDX_W-1:0] cfg_index,
  input wire logic [CFG_W-1:0]     cfg_data
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result beat present straight after reset");

  a_reset_full: assert property (@(posedge clk) !rst_n |=> full)
    else $error("input taken during counter clearing");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_data)))
    else $error("waiting result beat changed or vanished");

  a_none: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !out_data.found) |->
      (out_data.assigned_center == '0 && out_data.member_slot == '0))
    else $error("result without a centre carries an index or slot");

  a_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_data.found) |-> (out_data.member_slot != '0))
    else $error("chosen centre reports an empty member slot");

endmodule

bind periodic_nearest_center_assign pnca_checker u_pnca_checker (.*);
`default_nettype wire
